@@ hdl/dcmt_pkg.sv @@
// Shared constants, codes and the search token type for the channel map table.
package dcmt_pkg;

  localparam int DEF_TABLE_DEPTH  = 32;
  localparam int DEF_CHANNEL_BITS = 8;

  localparam int MODE_W      = 2;
  localparam int CRATE_W     = 5;
  localparam int SLOT_W      = 5;
  localparam int LOGICAL_W   = 16;
  localparam int INDEX_OUT_W = 5;
  localparam int COUNT_OUT_W = 6;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND  = 2'd2;

  // Control part of a find item as it walks down the row of cells.
  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic [CRATE_W-1:0]   crate;
    logic [SLOT_W-1:0]    slot;
    logic [LOGICAL_W-1:0] logical;
  } token_t;

endpackage

@@ hdl/dcmt_cell.sv @@
// One table entry together with the search stage that checks it.
module dcmt_cell #(
  parameter int CHANNEL_BITS = dcmt_pkg::DEF_CHANNEL_BITS,
  parameter int IDX_W        = 5,
  parameter int CELL_ID      = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [dcmt_pkg::CRATE_W-1:0]   wr_crate,
  input  logic [dcmt_pkg::SLOT_W-1:0]    wr_slot,
  input  logic [CHANNEL_BITS-1:0]        wr_lo,
  input  logic [CHANNEL_BITS-1:0]        wr_hi,
  input  logic [dcmt_pkg::LOGICAL_W-1:0] wr_first,
  input  logic                           wr_rev,
  input  logic                           live,
  input  dcmt_pkg::token_t               tok_in,
  input  logic [CHANNEL_BITS-1:0]        chan_in,
  input  logic [IDX_W-1:0]               idx_in,
  output dcmt_pkg::token_t               tok_out,
  output logic [CHANNEL_BITS-1:0]        chan_out,
  output logic [IDX_W-1:0]               idx_out
);

  logic [dcmt_pkg::CRATE_W-1:0]   crate;
  logic [dcmt_pkg::SLOT_W-1:0]    slot;
  logic [CHANNEL_BITS-1:0]        lo;
  logic [CHANNEL_BITS-1:0]        hi;
  logic [dcmt_pkg::LOGICAL_W-1:0] first;
  logic                           rev;

  logic                           match;
  logic [CHANNEL_BITS-1:0]        offset;
  dcmt_pkg::token_t               tok_next;
  logic [IDX_W-1:0]               idx_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      crate <= wr_crate;
      slot  <= wr_slot;
      lo    <= wr_lo;
      hi    <= wr_hi;
      first <= wr_first;
      rev   <= wr_rev;
    end
  end

  // An earlier cell that already matched wins, so only an unmatched token looks here.
  assign match = tok_in.valid && !tok_in.hit && live &&
                 (tok_in.crate == crate) && (tok_in.slot == slot) &&
                 (lo <= chan_in) && (chan_in <= hi);

  assign offset = rev ? (hi - chan_in) : (chan_in - lo);

  always_comb begin
    tok_next = tok_in;
    idx_next = idx_in;
    if (match) begin
      tok_next.hit     = 1'b1;
      tok_next.logical = first + dcmt_pkg::LOGICAL_W'(offset);
      idx_next         = IDX_W'(CELL_ID);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    chan_out <= chan_in;
    idx_out  <= idx_next;
  end

endmodule

@@ hdl/detector_channel_map_table_unit.sv @@
// Top level of the channel map table: item handshake, entry count and the row of cells.
//
// Input items carry a mode (clear, add, find) with crate, slot, range and channel
// fields; each accepted item yields exactly one result item on the output channel.
// Both channels use valid and stall; an item moves on an edge with valid high and
// stall low.
// Clear and add are settled in the cycle the item is accepted; the result is
// presented on the next cycle, and another item may follow unless the result is stalled.
// A find walks a token down the row of TABLE_DEPTH cells, one cell per cycle, and
// the first matching cell marks it. The token passes the cell registers and then
// the output register; no new item is taken while the token is in the row or in
// the cycle it leaves the row.
// Results sit in an output register; a new item is taken while the held result is
// being taken in the same cycle, and held off while the receiver stalls it.
// Reset empties the table (the count goes to zero) and drops any search in flight
// and any held result. Entry contents are not cleared; entries past the count are
// never looked at.
module detector_channel_map_table_unit #(
  parameter int TABLE_DEPTH  = dcmt_pkg::DEF_TABLE_DEPTH,
  parameter int CHANNEL_BITS = dcmt_pkg::DEF_CHANNEL_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dcmt_pkg::MODE_W-1:0]      mode,
  input  logic [dcmt_pkg::CRATE_W-1:0]     crate,
  input  logic [dcmt_pkg::SLOT_W-1:0]      slot,
  input  logic [CHANNEL_BITS-1:0]          range_start,
  input  logic [CHANNEL_BITS-1:0]          range_end,
  input  logic [dcmt_pkg::LOGICAL_W-1:0]   first_logical,
  input  logic [CHANNEL_BITS-1:0]          channel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             hit,
  output logic [dcmt_pkg::INDEX_OUT_W-1:0] entry_index,
  output logic [dcmt_pkg::LOGICAL_W-1:0]   logical_channel,
  output logic [dcmt_pkg::COUNT_OUT_W-1:0] entry_count,
  output logic                             full_error
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic                    state;
  logic                    state_next;
  logic [CNT_W-1:0]        used;
  logic                    accept;
  logic                    table_full;
  logic                    add_ok;
  logic                    rev;
  logic [CHANNEL_BITS-1:0] new_lo;
  logic [CHANNEL_BITS-1:0] new_hi;
  logic [31:0]             used_wide;
  logic [31:0]             used_inc_wide;
  logic [31:0]             idx_wide;

  dcmt_pkg::token_t        tok  [0:TABLE_DEPTH];
  logic [CHANNEL_BITS-1:0] chan [0:TABLE_DEPTH];
  logic [IDX_W-1:0]        idx  [0:TABLE_DEPTH];

  assign in_stall   = (state == ST_SEARCH) || (out_valid && out_stall);
  assign accept     = in_valid && !in_stall;
  assign table_full = (used >= CNT_W'(TABLE_DEPTH));
  assign add_ok     = accept && (mode == dcmt_pkg::MODE_ADD) && !table_full;

  // The stored range is always ascending; the flag remembers a swap.
  assign rev    = range_start > range_end;
  assign new_lo = rev ? range_end : range_start;
  assign new_hi = rev ? range_start : range_end;

  assign used_wide     = 32'(used);
  assign used_inc_wide = 32'(used) + 32'd1;
  assign idx_wide      = 32'(idx[TABLE_DEPTH]);

  always_comb begin
    tok[0].valid   = accept && (mode == dcmt_pkg::MODE_FIND);
    tok[0].hit     = 1'b0;
    tok[0].crate   = crate;
    tok[0].slot    = slot;
    tok[0].logical = '0;
    chan[0]        = channel;
    idx[0]         = '0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    dcmt_cell #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .IDX_W        (IDX_W),
      .CELL_ID      (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (add_ok && (used == CNT_W'(i))),
      .wr_crate (crate),
      .wr_slot  (slot),
      .wr_lo    (new_lo),
      .wr_hi    (new_hi),
      .wr_first (first_logical),
      .wr_rev   (rev),
      .live     (used > CNT_W'(i)),
      .tok_in   (tok[i]),
      .chan_in  (chan[i]),
      .idx_in   (idx[i]),
      .tok_out  (tok[i+1]),
      .chan_out (chan[i+1]),
      .idx_out  (idx[i+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (mode == dcmt_pkg::MODE_FIND)) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tok[TABLE_DEPTH].valid) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (accept && (mode == dcmt_pkg::MODE_CLEAR)) begin
      used <= '0;
    end else if (add_ok) begin
      used <= used + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && (mode != dcmt_pkg::MODE_FIND)) begin
      out_valid <= 1'b1;
    end else if (tok[TABLE_DEPTH].valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (mode != dcmt_pkg::MODE_FIND)) begin
      hit             <= 1'b0;
      logical_channel <= '0;
      unique case (mode)
        dcmt_pkg::MODE_CLEAR: begin
          entry_index <= '0;
          entry_count <= '0;
          full_error  <= 1'b0;
        end
        dcmt_pkg::MODE_ADD: begin
          if (table_full) begin
            entry_index <= '0;
            entry_count <= used_wide[dcmt_pkg::COUNT_OUT_W-1:0];
            full_error  <= 1'b1;
          end else begin
            entry_index <= used_wide[dcmt_pkg::INDEX_OUT_W-1:0];
            entry_count <= used_inc_wide[dcmt_pkg::COUNT_OUT_W-1:0];
            full_error  <= 1'b0;
          end
        end
        default: begin
          // Unused mode: only the count is reported.
          entry_index <= '0;
          entry_count <= used_wide[dcmt_pkg::COUNT_OUT_W-1:0];
          full_error  <= 1'b0;
        end
      endcase
    end else if (tok[TABLE_DEPTH].valid) begin
      hit             <= tok[TABLE_DEPTH].hit;
      entry_index     <= idx_wide[dcmt_pkg::INDEX_OUT_W-1:0];
      logical_channel <= tok[TABLE_DEPTH].logical;
      entry_count     <= used_wide[dcmt_pkg::COUNT_OUT_W-1:0];
      full_error      <= 1'b0;
    end
  end

endmodule
